// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion shorthands for the sprite camera projection checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define SCP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication that is also checked while reset is high.
`define SCP_ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: design/scp_pkg.sv
// ----------------------------------------------------------------------------
// scp_pkg
// Register indexes, field widths and pipeline timing of the sprite
// camera projection block.
// ----------------------------------------------------------------------------
package scp_pkg;

   localparam int POS_W   = 24;
   localparam int OFF_W   = 25;
   localparam int DIR_W   = 18;
   localparam int INV_W   = 24;
   localparam int HSW_W   = 11;
   localparam int CAM_W   = 32;
   localparam int PIX_W   = 16;
   localparam int HALF_W  = 15;
   localparam int CSR_A_W = 3;

   localparam logic [CSR_A_W-1:0] REG_VIEWER_X  = 3'd0;
   localparam logic [CSR_A_W-1:0] REG_VIEWER_Y  = 3'd1;
   localparam logic [CSR_A_W-1:0] REG_FACING_X  = 3'd2;
   localparam logic [CSR_A_W-1:0] REG_FACING_Y  = 3'd3;
   localparam logic [CSR_A_W-1:0] REG_PLANE_X   = 3'd4;
   localparam logic [CSR_A_W-1:0] REG_PLANE_Y   = 3'd5;
   localparam logic [CSR_A_W-1:0] REG_INV_DET   = 3'd6;
   localparam logic [CSR_A_W-1:0] REG_HALF_SCR  = 3'd7;

   // Square root runs on offset squares and yields OFF_W result bits.
   localparam int SQ_IN_W = 2 * OFF_W;
   localparam int QUO_W   = PIX_W;
   // Three stages before the root, one per root bit, one output register.
   localparam int LATENCY = 3 + OFF_W + 1;

endpackage

// File: design/scp_sqrt.sv
// ----------------------------------------------------------------------------
// scp_sqrt
// Pipelined integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module scp_sqrt #(
   parameter int IN_W  = 50,
   parameter int OUT_W = 25
) (
   input  logic             clock,
   input  logic [IN_W-1:0]  radicand,
   output logic [OUT_W-1:0] root
);

   localparam int TW = 2 * OUT_W + 1;

   logic [TW-1:0]    rem_ff  [OUT_W+1];
   logic [OUT_W-1:0] root_ff [OUT_W+1];

   assign rem_ff[0]  = TW'(radicand);
   assign root_ff[0] = '0;

   for (genvar k = 0; k < OUT_W; k++) begin : g_step
      localparam int B = OUT_W - 1 - k;
      logic [TW-1:0] trial;

      // (r + 2^B)^2 - r^2 for a partial root r that has only bits above B.
      assign trial = (TW'(root_ff[k]) << (B + 1)) + (TW'(1) << (2 * B));

      always_ff @(posedge clock) begin
         if (rem_ff[k] >= trial) begin
            rem_ff[k+1]  <= rem_ff[k] - trial;
            root_ff[k+1] <= root_ff[k] | (OUT_W'(1) << B);
         end else begin
            rem_ff[k+1]  <= rem_ff[k];
            root_ff[k+1] <= root_ff[k];
         end
      end
   end

   assign root = root_ff[OUT_W];

endmodule

// File: design/scp_div.sv
// ----------------------------------------------------------------------------
// scp_div
// Pipelined unsigned restoring divider with a quotient overflow flag.
// ----------------------------------------------------------------------------
module scp_div #(
   parameter int NUM_W = 44,
   parameter int DEN_W = 31,
   parameter int Q_W   = 16
) (
   input  logic             clock,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic [Q_W-1:0]   quot,
   output logic             ovf
);

   localparam int CW = ((NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W) + 1;

   logic [CW-1:0]    rem_ff [Q_W+1];
   logic [DEN_W-1:0] den_ff [Q_W+1];
   logic [Q_W-1:0]   q_ff   [Q_W+1];
   logic             ovf_ff [Q_W+1];

   // The first stage flags quotients that do not fit in Q_W bits.
   always_ff @(posedge clock) begin
      rem_ff[0] <= CW'(numer);
      den_ff[0] <= denom;
      q_ff[0]   <= '0;
      ovf_ff[0] <= CW'(numer) >= (CW'(denom) << Q_W);
   end

   for (genvar k = 0; k < Q_W; k++) begin : g_step
      localparam int B = Q_W - 1 - k;
      logic [CW-1:0] trial;

      assign trial = CW'(den_ff[k]) << B;

      always_ff @(posedge clock) begin
         den_ff[k+1] <= den_ff[k];
         ovf_ff[k+1] <= ovf_ff[k];
         if (rem_ff[k] >= trial) begin
            rem_ff[k+1] <= rem_ff[k] - trial;
            q_ff[k+1]   <= q_ff[k] | (Q_W'(1) << B);
         end else begin
            rem_ff[k+1] <= rem_ff[k];
            q_ff[k+1]   <= q_ff[k];
         end
      end
   end

   assign quot = q_ff[Q_W];
   assign ovf  = ovf_ff[Q_W];

endmodule

// File: design/sprite_camera_projection_top.sv
// ----------------------------------------------------------------------------
// sprite_camera_projection_top
// Projects entity positions into camera space and onto the screen.
// ----------------------------------------------------------------------------
// Usage: write the viewer, facing, camera plane, inverse determinant and
// half screen width through the csr_ port while no item is in flight.
// An entity position transfers at a rising edge with start high and busy
// low. busy is always low, so one entity can enter every cycle.
// Each result appears on the rsp_ ports for one cycle with rsp_valid high,
// in entry order. The square root is the longest path: it resolves one
// distance bit per stage after three stages of offset and square
// arithmetic, and the screen column and sprite height dividers run
// alongside it with one quotient bit per stage.
// Throughput is one result per cycle. The receiver cannot stall, so no
// backpressure exists. Reset clears all in-flight items and loads the
// register defaults.
// ----------------------------------------------------------------------------
module sprite_camera_projection_top #(
   parameter int SCREEN_HEIGHT = 480
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [scp_pkg::POS_W-1:0]        req_entity_x,
   input  logic [scp_pkg::POS_W-1:0]        req_entity_y,
   input  logic                             csr_write_en,
   input  logic [scp_pkg::CSR_A_W-1:0]      csr_index,
   input  logic [scp_pkg::POS_W-1:0]        csr_wdata,
   output logic                             rsp_valid,
   output logic signed [scp_pkg::OFF_W-1:0] rsp_offset_x,
   output logic signed [scp_pkg::OFF_W-1:0] rsp_offset_y,
   output logic [scp_pkg::OFF_W-1:0]        rsp_distance,
   output logic signed [scp_pkg::CAM_W-1:0] rsp_camera_x,
   output logic signed [scp_pkg::CAM_W-1:0] rsp_camera_depth,
   output logic signed [scp_pkg::PIX_W-1:0] rsp_screen_column,
   output logic [scp_pkg::PIX_W-1:0]        rsp_height_px,
   output logic [scp_pkg::HALF_W-1:0]       rsp_sprite_half_height,
   output logic                             rsp_behind_viewer
);
   import scp_pkg::*;

   localparam int PROD_W  = DIR_W + OFF_W;
   localparam int T_W     = PROD_W + 1 - 16;
   localparam int M_W     = T_W + INV_W;
   localparam int SH_W    = M_W - 16;
   localparam int CP_W    = HSW_W + 1 + CAM_W + 1;
   localparam int MAG_W   = CP_W - 1;
   localparam int HNUM    = SCREEN_HEIGHT * 65536;
   localparam int HNUM_W  = $clog2(HNUM + 1);
   localparam int SIDE_D  = 3 + OFF_W - 5;
   localparam int SIGN_D  = 3 + OFF_W - 7;
   localparam int DIVO_D  = SIGN_D - (QUO_W + 1);

   typedef struct packed {
      logic signed [OFF_W-1:0] dx;
      logic signed [OFF_W-1:0] dy;
      logic signed [CAM_W-1:0] cx;
      logic signed [CAM_W-1:0] cy;
      logic                    behind;
   } side_type;

   typedef struct packed {
      logic [QUO_W-1:0] col_q;
      logic             col_ovf;
      logic [QUO_W-1:0] hgt_q;
      logic             hgt_ovf;
   } divo_type;

   // Configuration registers.
   logic [POS_W-1:0]        viewer_x_ff, viewer_y_ff;
   logic signed [DIR_W-1:0] facing_x_ff, facing_y_ff, plane_x_ff, plane_y_ff;
   logic signed [INV_W-1:0] inv_det_ff;
   logic [HSW_W-1:0]        half_scr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         viewer_x_ff <= '0;
         viewer_y_ff <= '0;
         facing_x_ff <= DIR_W'(65536);
         facing_y_ff <= '0;
         plane_x_ff  <= '0;
         plane_y_ff  <= DIR_W'(43254);
         inv_det_ff  <= INV_W'(65536);
         half_scr_ff <= HSW_W'(320);
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_VIEWER_X: viewer_x_ff <= csr_wdata;
            REG_VIEWER_Y: viewer_y_ff <= csr_wdata;
            REG_FACING_X: facing_x_ff <= csr_wdata[DIR_W-1:0];
            REG_FACING_Y: facing_y_ff <= csr_wdata[DIR_W-1:0];
            REG_PLANE_X:  plane_x_ff  <= csr_wdata[DIR_W-1:0];
            REG_PLANE_Y:  plane_y_ff  <= csr_wdata[DIR_W-1:0];
            REG_INV_DET:  inv_det_ff  <= csr_wdata[INV_W-1:0];
            REG_HALF_SCR: half_scr_ff <= csr_wdata[HSW_W-1:0];
            default:      half_scr_ff <= half_scr_ff;
         endcase
      end
   end

   // Valid bits travel alongside the datapath.
   logic [LATENCY-1:0] vld_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LATENCY-2:0], start & ~busy};
      end
   end

   assign rsp_valid = vld_ff[LATENCY-1];

   // Stage 1: offsets.
   logic signed [OFF_W-1:0] dx1_ff, dy1_ff;

   always_ff @(posedge clock) begin
      dx1_ff <= $signed({1'b0, req_entity_x}) - $signed({1'b0, viewer_x_ff});
      dy1_ff <= $signed({1'b0, req_entity_y}) - $signed({1'b0, viewer_y_ff});
   end

   // Stage 2: cross products and squares.
   logic signed [PROD_W-1:0]  pa_in, pb_in, pc_in, pd_in;
   logic signed [PROD_W-1:0]  pa_ff, pb_ff, pc_ff, pd_ff;
   logic signed [SQ_IN_W-1:0] sqx_in, sqy_in;
   logic [SQ_IN_W-2:0]        sqx_ff, sqy_ff;
   logic signed [OFF_W-1:0]   dx2_ff, dy2_ff;

   assign pa_in  = PROD_W'(facing_y_ff) * PROD_W'(dx1_ff);
   assign pb_in  = PROD_W'(facing_x_ff) * PROD_W'(dy1_ff);
   assign pc_in  = PROD_W'(plane_x_ff) * PROD_W'(dy1_ff);
   assign pd_in  = PROD_W'(plane_y_ff) * PROD_W'(dx1_ff);
   assign sqx_in = SQ_IN_W'(dx1_ff) * SQ_IN_W'(dx1_ff);
   assign sqy_in = SQ_IN_W'(dy1_ff) * SQ_IN_W'(dy1_ff);

   always_ff @(posedge clock) begin
      pa_ff  <= pa_in;
      pb_ff  <= pb_in;
      pc_ff  <= pc_in;
      pd_ff  <= pd_in;
      sqx_ff <= sqx_in[SQ_IN_W-2:0];
      sqy_ff <= sqy_in[SQ_IN_W-2:0];
      dx2_ff <= dx1_ff;
      dy2_ff <= dy1_ff;
   end

   // Stage 3: differences floored to Q.16, and the sum of squares.
   logic signed [PROD_W:0]    lat_in, dep_in;
   logic signed [T_W-1:0]     tx3_ff, ty3_ff;
   logic [SQ_IN_W-1:0]        sum3_ff;
   logic signed [OFF_W-1:0]   dx3_ff, dy3_ff;

   assign lat_in = {pa_ff[PROD_W-1], pa_ff} - {pb_ff[PROD_W-1], pb_ff};
   assign dep_in = {pc_ff[PROD_W-1], pc_ff} - {pd_ff[PROD_W-1], pd_ff};

   always_ff @(posedge clock) begin
      tx3_ff  <= lat_in[PROD_W:16];
      ty3_ff  <= dep_in[PROD_W:16];
      sum3_ff <= {1'b0, sqx_ff} + {1'b0, sqy_ff};
      dx3_ff  <= dx2_ff;
      dy3_ff  <= dy2_ff;
   end

   // Stage 4: scale by the inverse determinant.
   logic signed [M_W-1:0]   mx_in, my_in, mx4_ff, my4_ff;
   logic signed [OFF_W-1:0] dx4_ff, dy4_ff;

   assign mx_in = M_W'(tx3_ff) * M_W'(inv_det_ff);
   assign my_in = M_W'(ty3_ff) * M_W'(inv_det_ff);

   always_ff @(posedge clock) begin
      mx4_ff <= mx_in;
      my4_ff <= my_in;
      dx4_ff <= dx3_ff;
      dy4_ff <= dy3_ff;
   end

   // Stage 5: floor and saturate to Q16.16.
   logic signed [SH_W-1:0]  shx, shy;
   logic signed [CAM_W-1:0] cx_in, cy_in;
   side_type                side5_ff;

   assign shx = mx4_ff[M_W-1:16];
   assign shy = my4_ff[M_W-1:16];

   always_comb begin
      if (shx > SH_W'(signed'(32'h7FFF_FFFF)) && !shx[SH_W-1]) begin
         cx_in = {1'b0, {(CAM_W-1){1'b1}}};
      end else if (shx[SH_W-1] && shx[SH_W-2:CAM_W-1] != '1) begin
         cx_in = {1'b1, {(CAM_W-1){1'b0}}};
      end else begin
         cx_in = shx[CAM_W-1:0];
      end
      if (shy > SH_W'(signed'(32'h7FFF_FFFF)) && !shy[SH_W-1]) begin
         cy_in = {1'b0, {(CAM_W-1){1'b1}}};
      end else if (shy[SH_W-1] && shy[SH_W-2:CAM_W-1] != '1) begin
         cy_in = {1'b1, {(CAM_W-1){1'b0}}};
      end else begin
         cy_in = shy[CAM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      side5_ff.dx     <= dx4_ff;
      side5_ff.dy     <= dy4_ff;
      side5_ff.cx     <= cx_in;
      side5_ff.cy     <= cy_in;
      side5_ff.behind <= (cy_in[CAM_W-1] || cy_in == '0);
   end

   // Stage 6: column numerator, half screen width times (depth + lateral).
   logic signed [CAM_W:0]  csum;
   logic signed [CP_W-1:0] cp6_ff;
   logic [CAM_W-2:0]       cy6_ff;

   assign csum = {side5_ff.cx[CAM_W-1], side5_ff.cx} + {side5_ff.cy[CAM_W-1], side5_ff.cy};

   always_ff @(posedge clock) begin
      cp6_ff <= CP_W'($signed({1'b0, half_scr_ff})) * CP_W'(csum);
      cy6_ff <= side5_ff.cy[CAM_W-2:0];
   end

   // Stage 7: magnitude and sign for the truncating division.
   logic [MAG_W-1:0] mag7_ff;
   logic             neg7_ff;
   logic [CAM_W-2:0] cy7_ff;
   logic [CP_W-1:0]  cp_abs;

   assign cp_abs = cp6_ff[CP_W-1] ? CP_W'(-cp6_ff) : CP_W'(cp6_ff);

   always_ff @(posedge clock) begin
      mag7_ff <= cp_abs[MAG_W-1:0];
      neg7_ff <= cp6_ff[CP_W-1];
      cy7_ff  <= cy6_ff;
   end

   // Dividers run in parallel from stage 7.
   logic [QUO_W-1:0] col_q, hgt_q;
   logic             col_ovf, hgt_ovf;
   divo_type         divo;

   scp_div #(.NUM_W(MAG_W), .DEN_W(CAM_W - 1), .Q_W(QUO_W)) u_col_div (
      .clock (clock),
      .numer (mag7_ff),
      .denom (cy7_ff),
      .quot  (col_q),
      .ovf   (col_ovf)
   );

   scp_div #(.NUM_W(HNUM_W), .DEN_W(CAM_W - 1), .Q_W(QUO_W)) u_hgt_div (
      .clock (clock),
      .numer (HNUM_W'(HNUM)),
      .denom (cy7_ff),
      .quot  (hgt_q),
      .ovf   (hgt_ovf)
   );

   assign divo = {col_q, col_ovf, hgt_q, hgt_ovf};

   logic [OFF_W-1:0] root;

   scp_sqrt #(.IN_W(SQ_IN_W), .OUT_W(OFF_W)) u_sqrt (
      .clock    (clock),
      .radicand (sum3_ff),
      .root     (root)
   );

   // Delay lines that align everything with the square root output.
   side_type side_ff [SIDE_D];
   logic     neg_ff  [SIGN_D];
   divo_type divo_ff [DIVO_D];

   always_ff @(posedge clock) begin
      side_ff[0] <= side5_ff;
      neg_ff[0]  <= neg7_ff;
      divo_ff[0] <= divo;
      for (int i = 1; i < SIDE_D; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
      for (int i = 1; i < SIGN_D; i++) begin
         neg_ff[i] <= neg_ff[i-1];
      end
      for (int i = 1; i < DIVO_D; i++) begin
         divo_ff[i] <= divo_ff[i-1];
      end
   end

   side_type side_a;
   divo_type divo_a;
   logic     neg_a;

   assign side_a = side_ff[SIDE_D-1];
   assign divo_a = divo_ff[DIVO_D-1];
   assign neg_a  = neg_ff[SIGN_D-1];

   // Output stage: saturation and the behind-viewer override.
   logic signed [PIX_W-1:0] col_in;
   logic [PIX_W-1:0]        hgt_in;

   always_comb begin
      priority if (side_a.behind) begin
         col_in = side_a.cx[CAM_W-1] ? {1'b1, {(PIX_W-1){1'b0}}}
                                     : {1'b0, {(PIX_W-1){1'b1}}};
         hgt_in = '1;
      end else begin
         if (neg_a) begin
            if (divo_a.col_ovf || divo_a.col_q > {1'b1, {(PIX_W-1){1'b0}}}) begin
               col_in = {1'b1, {(PIX_W-1){1'b0}}};
            end else begin
               col_in = PIX_W'(0) - divo_a.col_q;
            end
         end else begin
            if (divo_a.col_ovf || divo_a.col_q[PIX_W-1]) begin
               col_in = {1'b0, {(PIX_W-1){1'b1}}};
            end else begin
               col_in = divo_a.col_q;
            end
         end
         hgt_in = divo_a.hgt_ovf ? '1 : divo_a.hgt_q;
      end
   end

   always_ff @(posedge clock) begin
      rsp_offset_x           <= side_a.dx;
      rsp_offset_y           <= side_a.dy;
      rsp_distance           <= root;
      rsp_camera_x           <= side_a.cx;
      rsp_camera_depth       <= side_a.cy;
      rsp_screen_column      <= col_in;
      rsp_height_px          <= hgt_in;
      rsp_sprite_half_height <= hgt_in[PIX_W-1:1];
      rsp_behind_viewer      <= side_a.behind;
   end

endmodule

// File: design/scp_checker.sv
// ----------------------------------------------------------------------------
// scp_checker
// Port-level checks of the sprite camera projection block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scp_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic signed [31:0] rsp_camera_depth,
   input logic [15:0]        rsp_height_px,
   input logic [14:0]        rsp_sprite_half_height,
   input logic               rsp_behind_viewer
);

   logic depth_not_pos;
   logic heights_sat;
   logic half_ok;

   assign depth_not_pos = (rsp_camera_depth <= 32'sd0);
   assign heights_sat   = (rsp_height_px == 16'hFFFF) && (rsp_sprite_half_height == 15'h7FFF);
   assign half_ok       = (rsp_sprite_half_height == rsp_height_px[15:1]);

   // The pipeline never refuses an entity.
   `SCP_ASSERT_IMP(a_never_busy, clock, reset, start, !busy)

   // The behind flag must agree with the sign of the reported depth.
   `SCP_ASSERT_IMP(a_behind_flag, clock, reset, rsp_valid, rsp_behind_viewer == depth_not_pos)

   // An entity behind the viewer saturates both heights.
   `SCP_ASSERT_IMP(a_behind_sat, clock, reset, rsp_valid && rsp_behind_viewer, heights_sat)

   // Half height always follows the full height.
   `SCP_ASSERT_IMP(a_half, clock, reset, rsp_valid, half_ok)

   // Reset flushes every transfer in flight.
   `SCP_ASSERT_NEXT(a_reset_flush, clock, reset, !rsp_valid)

endmodule

bind sprite_camera_projection_top scp_checker u_scp_checker (
   .clock                  (clock),
   .reset                  (reset),
   .start                  (start),
   .busy                   (busy),
   .rsp_valid              (rsp_valid),
   .rsp_camera_depth       (rsp_camera_depth),
   .rsp_height_px          (rsp_height_px),
   .rsp_sprite_half_height (rsp_sprite_half_height),
   .rsp_behind_viewer      (rsp_behind_viewer)
);
